// ----- design/spms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spms_pkg;

	localparam int unsigned BUTTON_COUNT = 12;
	localparam int unsigned SRC_WIDTH    = 32;
	localparam int unsigned IDX_WIDTH    = 5;
	localparam int unsigned HALF_COUNT   = 6;
	localparam int unsigned ENTRY_WIDTH  = 6;
	localparam int unsigned CFG_WIDTH    = 36;
	localparam int unsigned WIRE_WIDTH   = 16;
	localparam int unsigned POS_WIDTH    = 5;

	// SNES button positions of the opposing direction pairs
	localparam int unsigned SNES_UP    = 4;
	localparam int unsigned SNES_DOWN  = 5;
	localparam int unsigned SNES_LEFT  = 6;
	localparam int unsigned SNES_RIGHT = 7;

	localparam logic [POS_WIDTH-1:0]  POS_DONE   = 5'd16;
	localparam logic [WIRE_WIDTH-1:0] WIRE_IDLE  = 16'hFFFF;
	localparam logic [3:0]            WIRE_PAD   = 4'hF;

	// input command codes
	localparam logic CMD_LATCH = 1'b0;
	localparam logic CMD_CLOCK = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_MAP_FIRST = 2'd0;
	localparam logic [1:0] CFG_MAP_LAST  = 2'd1;
	localparam logic [1:0] CFG_ALLOWED   = 2'd2;

	typedef struct packed {
		logic                 en;
		logic [IDX_WIDTH-1:0] src;
	} map_entry_t;

	typedef struct packed {
		map_entry_t [BUTTON_COUNT-1:0] entry;
		logic [SRC_WIDTH-1:0]          allowed;
	} map_cfg_t;

	// shifter control from the top level
	typedef struct packed {
		logic advance;
		logic cmd;
	} shift_ctl_t;

endpackage

`default_nettype wire

// ----- design/spms_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spms_cfg
	import spms_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [CFG_WIDTH-1:0] cfg_data,
	output map_cfg_t                  map_cfg
);

	logic [CFG_WIDTH-1:0] map_first_q;
	logic [CFG_WIDTH-1:0] map_last_q;
	logic [SRC_WIDTH-1:0] allowed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_first_q <= '0;
			map_last_q  <= '0;
			allowed_q   <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAP_FIRST: map_first_q <= cfg_data;
				CFG_MAP_LAST:  map_last_q  <= cfg_data;
				CFG_ALLOWED:   allowed_q   <= cfg_data[SRC_WIDTH-1:0];
				default: ;	// unused index, dropped
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < HALF_COUNT; i++) begin
			map_cfg.entry[i]            = map_first_q[i*ENTRY_WIDTH +: ENTRY_WIDTH];
			map_cfg.entry[i+HALF_COUNT] = map_last_q[i*ENTRY_WIDTH +: ENTRY_WIDTH];
		end
		map_cfg.allowed = allowed_q;
	end

endmodule

`default_nettype wire

// ----- design/spms_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spms_map
	import spms_pkg::*;
(
	input  wire map_cfg_t                map_cfg,
	input  wire logic [SRC_WIDTH-1:0]    source_buttons,
	input  wire logic                    link_up,
	output logic [BUTTON_COUNT-1:0]      pressed
);

	logic [BUTTON_COUNT-1:0] raw;
	logic                    bad;
	logic [BUTTON_COUNT-1:0] p;

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			raw[i] = map_cfg.entry[i].en & source_buttons[map_cfg.entry[i].src];
			// source not permitted by the mask
			if (map_cfg.entry[i].en && !map_cfg.allowed[map_cfg.entry[i].src])
				bad = 1'b1;
			// two enabled entries on one source bit
			for (int j = i + 1; j < BUTTON_COUNT; j++) begin
				if (map_cfg.entry[i].en && map_cfg.entry[j].en &&
				    map_cfg.entry[i].src == map_cfg.entry[j].src)
					bad = 1'b1;
			end
		end

		p = (link_up && !bad) ? raw : '0;
		if (p[SNES_UP] && p[SNES_DOWN]) begin
			p[SNES_UP]   = 1'b0;
			p[SNES_DOWN] = 1'b0;
		end
		if (p[SNES_LEFT] && p[SNES_RIGHT]) begin
			p[SNES_LEFT]  = 1'b0;
			p[SNES_RIGHT] = 1'b0;
		end
		pressed = p;
	end

endmodule

`default_nettype wire

// ----- design/spms_shift.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spms_shift
	import spms_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire shift_ctl_t              ctl,
	input  wire logic [BUTTON_COUNT-1:0] pressed,
	input  wire logic                    out_stall,
	output logic                         out_valid,
	output logic                         data_line,
	output logic [BUTTON_COUNT-1:0]      latched_pressed
);

	logic [WIRE_WIDTH-1:0] wire_q;
	logic [POS_WIDTH-1:0]  pos_q;
	logic [WIRE_WIDTH-1:0] wire_next;
	logic [POS_WIDTH-1:0]  pos_next;
	logic                  out_valid_q;
	logic                  data_q;
	logic [BUTTON_COUNT-1:0] pressed_q;

	always_comb begin
		wire_next = wire_q;
		pos_next  = pos_q;
		if (ctl.cmd == CMD_LATCH) begin
			wire_next = {WIRE_PAD, ~pressed};
			pos_next  = '0;
		end else if (pos_q < POS_DONE) begin
			pos_next = pos_q + POS_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_q      <= WIRE_IDLE;
			pos_q       <= POS_DONE;
			out_valid_q <= 1'b0;
		end else if (ctl.advance) begin
			wire_q      <= wire_next;
			pos_q       <= pos_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			data_q    <= pos_next[POS_WIDTH-1] | wire_next[pos_next[POS_WIDTH-2:0]];
			pressed_q <= ~wire_next[BUTTON_COUNT-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign data_line       = data_q;
	assign latched_pressed = pressed_q;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_DONE)
		else $error("shift position beyond end");

	a_pad_high: assert property (@(posedge clk) disable iff (!arst_n)
		wire_q[WIRE_WIDTH-1:BUTTON_COUNT] == WIRE_PAD)
		else $error("wire word pad bits not high");

	a_low_means_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !data_q |-> pressed_q != '0)
		else $error("data line low with no button held");

	a_latch_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance && ctl.cmd == CMD_LATCH |=> pos_q == '0)
		else $error("latch did not restart the shift");
`endif

endmodule

`default_nettype wire

// ----- design/snes_pad_mapper_shifter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// SNES pad mapper and serial shifter. Each input word is either a latch
// (cmd = 0) or a clock pulse (cmd = 1). A latch maps the 32-bit source
// button word through twelve configured entries into the SNES pressed set
// (empty when link_up is low or the mapping is invalid; an opposing
// direction pair that is fully held is released), stores it as an
// active-low 16-bit wire word and restarts the shift; a clock pulse moves
// the shift one bit on, stopping past bit 15. Every input word gives one
// output word: data_line after the step and the latched pressed set.
// Throughput is one word per clock while out_stall is low; a word goes
// through the input register, then the mapper and shift update into the
// output register. A new word is taken while a result waits, so
// in_stall only rises when both registers are full and out_stall is high.
// Configuration writes are always taken (cfg_ready is tied high) and must
// be made while no word is in flight; index 3 is ignored.

module snes_pad_mapper_shifter_core
	import spms_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [CFG_WIDTH-1:0]    cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    cmd,
	input  wire logic [SRC_WIDTH-1:0]    source_buttons,
	input  wire logic                    link_up,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         data_line,
	output logic [BUTTON_COUNT-1:0]      latched_pressed
);

	map_cfg_t                map_cfg;
	logic [BUTTON_COUNT-1:0] pressed;
	shift_ctl_t              ctl;

	// input stage
	logic                 valid_s1;
	logic                 cmd_s1;
	logic [SRC_WIDTH-1:0] buttons_s1;
	logic                 link_s1;
	logic                 advance;
	logic                 take;

	assign cfg_ready = 1'b1;

	// the stage moves on when the output register is empty or being drained
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1     <= cmd;
			buttons_s1 <= source_buttons;
			link_s1    <= link_up;
		end
	end

	spms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.map_cfg   (map_cfg)
	);

	spms_map u_map (
		.map_cfg        (map_cfg),
		.source_buttons (buttons_s1),
		.link_up        (link_s1),
		.pressed        (pressed)
	);

	assign ctl.advance = advance;
	assign ctl.cmd     = cmd_s1;

	spms_shift u_shift (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.pressed         (pressed),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.data_line       (data_line),
		.latched_pressed (latched_pressed)
	);

endmodule

`default_nettype wire
